@@ rtl/ssmp_pkg.sv @@
// Shared types and constants for the SQL startup message parser.
// Parse phases, result kinds, field codes and the fixed byte patterns.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ssmp_pkg;

   // parse phase of the byte-serial state machine
   typedef enum logic [2:0] {
      PH_LENGTH  = 3'd0,
      PH_VERSION = 3'd1,
      PH_KEY     = 3'd2,
      PH_VALUE   = 3'd3,
      PH_DONE    = 3'd4
   } phase_type;

   // kind of a result word
   typedef enum logic [2:0] {
      KIND_SSL        = 3'd0,
      KIND_VALUE_BYTE = 3'd1,
      KIND_COMMIT     = 3'd2,
      KIND_DISCARD    = 3'd3,
      KIND_FINISHED   = 3'd4
   } kind_type;

   // field codes; FIELD_NONE marks a key that is not reported
   localparam logic [1:0] FIELD_USER     = 2'd0;
   localparam logic [1:0] FIELD_DATABASE = 2'd1;
   localparam logic [1:0] FIELD_APP_NAME = 2'd2;
   localparam logic [1:0] FIELD_NONE     = 2'd3;

   localparam int NUM_FIELDS  = 3;
   localparam int MAX_RESULTS = 3;

   // configuration register indexes
   localparam logic REG_PARSE_DIRECTION = 1'b0;

   // header checks
   localparam logic [31:0] MIN_LENGTH     = 32'd16;
   localparam logic [15:0] PROTOCOL_MAJOR = 16'd3;
   localparam logic [15:0] SSL_SEG_LENGTH = 16'd8;
   localparam logic [15:0] OFFSET_MAX     = 16'hFFFF;
   localparam logic [4:0]  KEY_POS_MAX    = 5'd31;

   // header byte positions
   localparam logic [2:0] OFF_LENGTH_LAST  = 3'd3;
   localparam logic [2:0] OFF_VERSION_HI0  = 3'd4;
   localparam logic [2:0] OFF_VERSION_HI1  = 3'd5;
   localparam logic [2:0] OFF_HEADER_LAST  = 3'd7;

   // key names, first character at index 0
   localparam logic [0:3][7:0]  NAME_USER = "user";
   localparam logic [0:7][7:0]  NAME_DB   = "database";
   localparam logic [0:15][7:0] NAME_APP  = "application_name";

   // one result word
   typedef struct packed {
      kind_type   kind;
      logic [1:0] field_id;
      logic [7:0] value_byte;
      logic       marks_protocol;
      logic       last_of_run;
   } result_type;

   // SSL request bytes 00 00 00 08 04 d2 16 2f
   function automatic logic [7:0] ssl_byte(input logic [2:0] idx);
      logic [7:0] b;
      begin
         case (idx)
            3'd3:    b = 8'h08;
            3'd4:    b = 8'h04;
            3'd5:    b = 8'hd2;
            3'd6:    b = 8'h16;
            3'd7:    b = 8'h2f;
            default: b = 8'h00;
         endcase
         return b;
      end
   endfunction

   function automatic logic [4:0] name_len(input logic [1:0] field);
      logic [4:0] len;
      begin
         case (field)
            FIELD_USER:     len = 5'd4;
            FIELD_DATABASE: len = 5'd8;
            FIELD_APP_NAME: len = 5'd16;
            default:        len = 5'd0;
         endcase
         return len;
      end
   endfunction

   // character of a key name; only valid below name_len
   function automatic logic [7:0] name_char(input logic [1:0] field, input logic [4:0] pos);
      logic [7:0] c;
      begin
         case (field)
            FIELD_USER:     c = NAME_USER[pos[1:0]];
            FIELD_DATABASE: c = NAME_DB[pos[2:0]];
            FIELD_APP_NAME: c = NAME_APP[pos[3:0]];
            default:        c = 8'h00;
         endcase
         return c;
      end
   endfunction

   function automatic result_type make_result(input kind_type k, input logic [1:0] f,
                                              input logic [7:0] v, input logic m);
      result_type r;
      begin
         r.kind           = k;
         r.field_id       = f;
         r.value_byte     = v;
         r.marks_protocol = m;
         r.last_of_run    = 1'b0;
         return r;
      end
   endfunction

endpackage

`default_nettype wire

@@ rtl/sql_startup_message_parser_core.sv @@
// Channel   | Dir | Word contents
// req_      | in  | tdata[7:0] data_byte, [23:8] segment_length; tlast last_in_segment;
//           |     | tuser direction
// rsp_      | out | tdata[7:0] value_byte, [8] marks_protocol; tlast last_of_run;
//           |     | tuser[2:0] result_kind, [4:3] field_id
// csr_      | in  | APB register 0 at byte address 0: parse_direction
//
// One input word per cycle is taken when it gives at most one result and rsp_
// does not stall. A word that gives k results (at most three) loads them into
// the three-entry output buffer and holds req_tready low while the buffer
// drains to its last word. Parse state is updated at the edge the input word
// is accepted; results are visible on rsp_ in the following cycle. Stalls on
// rsp_ back up into req_ whenever the buffer holds a word. Reset is synchronous
// and needs no clearing pass.
// Depends on ssmp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sql_startup_message_parser_core (
   input  wire logic        clock,
   input  wire logic        reset,
   // input bytes
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // data_byte[7:0], segment_length[23:8]
   input  wire logic        req_tlast,   // last_in_segment
   input  wire logic        req_tuser,   // direction
   // results
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // value_byte[7:0], marks_protocol[8], zero fill
   output logic             rsp_tlast,   // last_of_run
   output logic [4:0]       rsp_tuser,   // result_kind[2:0], field_id[4:3]
   // configuration
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   // parse state
   ssmp_pkg::phase_type phase_ff, phase_in;
   logic [15:0] byte_offset_ff, byte_offset_in;
   logic [31:0] decl_len_ff, decl_len_in;
   logic [15:0] version_ff, version_in;
   logic        ssl_match_ff, ssl_match_in;
   logic [2:0]  key_cand_ff, key_cand_in;
   logic [4:0]  key_pos_ff, key_pos_in;
   logic [1:0]  open_field_ff, open_field_in;
   logic        parse_dir_ff, parse_dir_in;

   // output buffer
   ssmp_pkg::result_type buf_ff [ssmp_pkg::MAX_RESULTS];
   ssmp_pkg::result_type buf_in [ssmp_pkg::MAX_RESULTS];
   logic [1:0]  buf_count_ff, buf_count_in;

   // results of the word being accepted
   ssmp_pkg::result_type res_new [ssmp_pkg::MAX_RESULTS];
   logic [1:0]  res_count;

   // shared decode
   logic [7:0]  in_byte;
   logic [15:0] in_seglen;
   logic        req_fire, rsp_fire, active;
   logic [2:0]  hdr_off;
   logic        no_rem, seg_end, byte_zero;
   logic [31:0] decl_len_n;
   logic [15:0] version_n;
   logic        ssl_match_n, ssl_done, hdr_bad;
   logic [2:0]  key_cand_n;
   logic [1:0]  key_field;
   logic        key_empty;

   assign in_byte   = req_tdata[7:0];
   assign in_seglen = req_tdata[23:8];
   assign req_fire  = req_tvalid & req_tready;
   assign rsp_fire  = rsp_tvalid & rsp_tready;
   assign active    = req_fire && (phase_ff != ssmp_pkg::PH_DONE) && (req_tuser == parse_dir_ff);

   // segment end: flagged, or no more than one byte left
   assign no_rem    = {1'b0, in_seglen} <= ({1'b0, byte_offset_ff} + 17'd1);
   assign seg_end   = req_tlast || no_rem;
   assign byte_zero = (in_byte == 8'h00);
   assign hdr_off   = byte_offset_ff[2:0];
   assign key_empty = (key_pos_ff == 5'd0);

   // header collection and checks
   always_comb begin
      decl_len_n  = (hdr_off <= ssmp_pkg::OFF_LENGTH_LAST) ? {decl_len_ff[23:0], in_byte}
                                                           : decl_len_ff;
      version_n   = (hdr_off == ssmp_pkg::OFF_VERSION_HI0 || hdr_off == ssmp_pkg::OFF_VERSION_HI1)
                    ? {version_ff[7:0], in_byte} : version_ff;
      ssl_match_n = ssl_match_ff && (in_seglen == ssmp_pkg::SSL_SEG_LENGTH)
                    && (in_byte == ssmp_pkg::ssl_byte(hdr_off));
      ssl_done    = ssl_match_n && (hdr_off == ssmp_pkg::OFF_HEADER_LAST);
      hdr_bad     = seg_end
                    || (hdr_off >= ssmp_pkg::OFF_LENGTH_LAST && !ssl_match_n
                        && (decl_len_n < ssmp_pkg::MIN_LENGTH
                            || decl_len_n > {16'd0, in_seglen}))
                    || (hdr_off == ssmp_pkg::OFF_HEADER_LAST
                        && version_n != ssmp_pkg::PROTOCOL_MAJOR);
   end

   // key name matching: one comparator per name
   always_comb begin
      key_field = ssmp_pkg::FIELD_NONE;
      for (int i = 0; i < ssmp_pkg::NUM_FIELDS; i++) begin
         key_cand_n[i] = key_cand_ff[i]
                         && (key_pos_ff < ssmp_pkg::name_len(2'(i)))
                         && (ssmp_pkg::name_char(2'(i), key_pos_ff) == in_byte);
         if (key_cand_ff[i] && key_pos_ff == ssmp_pkg::name_len(2'(i)))
            key_field = 2'(i);
      end
   end

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (active) begin
         case (phase_ff)
            ssmp_pkg::PH_LENGTH,
            ssmp_pkg::PH_VERSION: begin
               if (ssl_done)
                  phase_in = ssmp_pkg::PH_LENGTH;
               else if (hdr_bad)
                  phase_in = ssmp_pkg::PH_DONE;
               else if (hdr_off == ssmp_pkg::OFF_LENGTH_LAST)
                  phase_in = ssmp_pkg::PH_VERSION;
               else if (hdr_off == ssmp_pkg::OFF_HEADER_LAST)
                  phase_in = ssmp_pkg::PH_KEY;
            end
            ssmp_pkg::PH_KEY: begin
               if (key_empty && (no_rem || byte_zero))
                  phase_in = ssmp_pkg::PH_DONE;
               else if (seg_end)
                  phase_in = ssmp_pkg::PH_DONE;
               else if (byte_zero)
                  phase_in = ssmp_pkg::PH_VALUE;
            end
            ssmp_pkg::PH_VALUE: begin
               if (seg_end)
                  phase_in = ssmp_pkg::PH_DONE;
               else if (byte_zero)
                  phase_in = ssmp_pkg::PH_KEY;
            end
            default: phase_in = phase_ff;
         endcase
      end
   end

   // results and data state
   always_comb begin
      byte_offset_in = byte_offset_ff;
      decl_len_in    = decl_len_ff;
      version_in     = version_ff;
      ssl_match_in   = ssl_match_ff;
      key_cand_in    = key_cand_ff;
      key_pos_in     = key_pos_ff;
      open_field_in  = open_field_ff;
      res_count      = 2'd0;
      for (int k = 0; k < ssmp_pkg::MAX_RESULTS; k++)
         res_new[k] = ssmp_pkg::make_result(ssmp_pkg::KIND_SSL, 2'd0, 8'd0, 1'b0);

      if (active) begin
         if (byte_offset_ff != ssmp_pkg::OFFSET_MAX)
            byte_offset_in = byte_offset_ff + 16'd1;
         case (phase_ff)
            ssmp_pkg::PH_LENGTH,
            ssmp_pkg::PH_VERSION: begin
               decl_len_in  = decl_len_n;
               version_in   = version_n;
               ssl_match_in = ssl_match_n;
               if (ssl_done) begin
                  res_new[0] = ssmp_pkg::make_result(ssmp_pkg::KIND_SSL, 2'd0, 8'd0, 1'b1);
                  res_count  = 2'd1;
                  // arm for the next segment
                  byte_offset_in = 16'd0;
                  decl_len_in    = 32'd0;
                  version_in     = 16'd0;
                  ssl_match_in   = 1'b1;
               end else if (hdr_bad) begin
                  res_new[0] = ssmp_pkg::make_result(ssmp_pkg::KIND_FINISHED, 2'd0, 8'd0, 1'b0);
                  res_count  = 2'd1;
               end else if (hdr_off == ssmp_pkg::OFF_HEADER_LAST) begin
                  key_pos_in    = 5'd0;
                  key_cand_in   = 3'b111;
                  open_field_in = ssmp_pkg::FIELD_NONE;
               end
            end
            ssmp_pkg::PH_KEY: begin
               if (key_empty && (no_rem || byte_zero)) begin
                  res_new[0] = ssmp_pkg::make_result(ssmp_pkg::KIND_FINISHED, 2'd0, 8'd0, 1'b0);
                  res_count  = 2'd1;
               end else if (byte_zero) begin
                  open_field_in = key_field;
                  if (seg_end) begin
                     // key ends on the last byte: empty value, cut off
                     if (key_field != ssmp_pkg::FIELD_NONE) begin
                        res_new[0] = ssmp_pkg::make_result(ssmp_pkg::KIND_DISCARD,
                                                           key_field, 8'd0, 1'b0);
                        res_new[1] = ssmp_pkg::make_result(ssmp_pkg::KIND_FINISHED,
                                                           2'd0, 8'd0, 1'b0);
                        res_count  = 2'd2;
                     end else begin
                        res_new[0] = ssmp_pkg::make_result(ssmp_pkg::KIND_FINISHED,
                                                           2'd0, 8'd0, 1'b0);
                        res_count  = 2'd1;
                     end
                  end
               end else begin
                  key_cand_in = key_cand_n;
                  if (key_pos_ff != ssmp_pkg::KEY_POS_MAX)
                     key_pos_in = key_pos_ff + 5'd1;
                  if (seg_end) begin
                     res_new[0] = ssmp_pkg::make_result(ssmp_pkg::KIND_FINISHED,
                                                        2'd0, 8'd0, 1'b0);
                     res_count  = 2'd1;
                  end
               end
            end
            ssmp_pkg::PH_VALUE: begin
               if (byte_zero) begin
                  // value complete
                  if (open_field_ff != ssmp_pkg::FIELD_NONE) begin
                     res_new[res_count] = ssmp_pkg::make_result(
                        ssmp_pkg::KIND_COMMIT, open_field_ff, 8'd0,
                        open_field_ff == ssmp_pkg::FIELD_USER);
                     res_count = res_count + 2'd1;
                  end
                  key_pos_in    = 5'd0;
                  key_cand_in   = 3'b111;
                  open_field_in = ssmp_pkg::FIELD_NONE;
               end else begin
                  if (open_field_ff != ssmp_pkg::FIELD_NONE) begin
                     res_new[res_count] = ssmp_pkg::make_result(
                        ssmp_pkg::KIND_VALUE_BYTE, open_field_ff, in_byte, 1'b0);
                     res_count = res_count + 2'd1;
                  end
                  if (seg_end && open_field_ff != ssmp_pkg::FIELD_NONE) begin
                     res_new[res_count] = ssmp_pkg::make_result(
                        ssmp_pkg::KIND_DISCARD, open_field_ff, 8'd0, 1'b0);
                     res_count = res_count + 2'd1;
                  end
               end
               if (seg_end) begin
                  res_new[res_count] = ssmp_pkg::make_result(
                     ssmp_pkg::KIND_FINISHED, 2'd0, 8'd0, 1'b0);
                  res_count = res_count + 2'd1;
               end
            end
            default: res_count = 2'd0;
         endcase
         if (res_count != 2'd0)
            res_new[res_count - 2'd1].last_of_run = 1'b1;
      end
   end

   // output buffer: load a new run or shift one word out
   assign req_tready = (buf_count_ff == 2'd0) || (buf_count_ff == 2'd1 && rsp_tready);

   always_comb begin
      buf_in       = buf_ff;
      buf_count_in = buf_count_ff;
      if (req_fire && res_count != 2'd0) begin
         buf_in       = res_new;
         buf_count_in = res_count;
      end else if (rsp_fire) begin
         for (int k = 0; k < ssmp_pkg::MAX_RESULTS - 1; k++)
            buf_in[k] = buf_ff[k + 1];
         buf_count_in = buf_count_ff - 2'd1;
      end
   end

   assign rsp_tvalid = (buf_count_ff != 2'd0);
   assign rsp_tdata  = {7'd0, buf_ff[0].marks_protocol, buf_ff[0].value_byte};
   assign rsp_tlast  = buf_ff[0].last_of_run;
   assign rsp_tuser  = {buf_ff[0].field_id, buf_ff[0].kind};

   // register port
   assign csr_pready = 1'b1;

   always_comb begin
      parse_dir_in = parse_dir_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready
          && csr_paddr[2] == ssmp_pkg::REG_PARSE_DIRECTION)
         parse_dir_in = csr_pwdata[0];
   end

   always_comb begin
      csr_prdata = 32'd0;
      if (csr_paddr[2] == ssmp_pkg::REG_PARSE_DIRECTION)
         csr_prdata = {31'd0, parse_dir_ff};
   end

   // control and parse state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= ssmp_pkg::PH_LENGTH;
         byte_offset_ff <= 16'd0;
         decl_len_ff    <= 32'd0;
         version_ff     <= 16'd0;
         ssl_match_ff   <= 1'b1;
         key_cand_ff    <= 3'b111;
         key_pos_ff     <= 5'd0;
         open_field_ff  <= ssmp_pkg::FIELD_NONE;
         parse_dir_ff   <= 1'b0;
         buf_count_ff   <= 2'd0;
      end else begin
         phase_ff       <= phase_in;
         byte_offset_ff <= byte_offset_in;
         decl_len_ff    <= decl_len_in;
         version_ff     <= version_in;
         ssl_match_ff   <= ssl_match_in;
         key_cand_ff    <= key_cand_in;
         key_pos_ff     <= key_pos_in;
         open_field_ff  <= open_field_in;
         parse_dir_ff   <= parse_dir_in;
         buf_count_ff   <= buf_count_in;
      end
   end

   // result payload, qualified by buf_count_ff
   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
   end

endmodule

`default_nettype wire

@@ rtl/ssmp_checker.sv @@
// Port-level checks for the SQL startup message parser core.
// Bound to sql_startup_message_parser_core; depends on ssmp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ssmp_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [23:0] req_tdata,
   input wire logic        req_tlast,
   input wire logic        req_tuser,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [15:0] rsp_tdata,
   input wire logic        rsp_tlast,
   input wire logic [4:0]  rsp_tuser,
   input wire logic        csr_psel,
   input wire logic        csr_penable,
   input wire logic        csr_pwrite,
   input wire logic [2:0]  csr_paddr,
   input wire logic [31:0] csr_pwdata,
   input wire logic [31:0] csr_prdata,
   input wire logic        csr_pready
);

   // a held result word keeps its contents
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)
                                    && $stable(rsp_tlast))
      else $error("result word changed while stalled");

   // an SSL report is always the only word of its run
   a_ssl_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[2:0] == ssmp_pkg::KIND_SSL |-> rsp_tlast)
      else $error("ssl report not closing its run");

   // finished closes its run, and nothing follows once it is taken
   a_fin_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[2:0] == ssmp_pkg::KIND_FINISHED |-> rsp_tlast)
      else $error("finished not closing its run");

   a_fin_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tuser[2:0] == ssmp_pkg::KIND_FINISHED |=> !rsp_tvalid)
      else $error("result after finished");

   // the register port never waits
   a_pready: assert property (@(posedge clock) disable iff (reset)
      csr_psel |-> csr_pready)
      else $error("register port stalled");

endmodule

bind sql_startup_message_parser_core ssmp_checker u_ssmp_checker (.*);

`default_nettype wire
